// File: hdl/srec_pkg.sv
// shared types and constants for the s-record line checksum checker
// no dependencies; imported by every module of the block
package srec_pkg;

    localparam int MAX_LINE_CHARS_DEF = 256;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] SUM_BASE     = 8'hFF;
    localparam logic [7:0] POS_MAX      = 8'hFF;

    typedef logic [2:0] t_status;
    localparam t_status STATUS_OK       = 3'd0;
    localparam t_status STATUS_ILLEGAL  = 3'd1;
    localparam t_status STATUS_SHORT    = 3'd2;
    localparam t_status STATUS_MISMATCH = 3'd3;
    localparam t_status STATUS_ODD      = 3'd4;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic       line_ok;
        t_status    status;
        logic [7:0] expected_sum;
        logic [7:0] computed_sum;
        logic [7:0] bad_character;
        logic [7:0] bad_position;
    } t_result;

    // classified character as it travels from front to back
    typedef struct packed {
        logic       end_of_line;
        logic       legal;
        logic [3:0] nibble;
        logic [7:0] character;
    } t_cls;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: hdl/srec_front.sv
// front end: accepts input transactions and classifies each character
// depends on srec_pkg; feeds srec_queue
module srec_front
    import srec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_cls      o_cls
);

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        begin
            // bit 4 flags a hex digit, low bits give its value
            case (c) inside
                [8'h30:8'h39]: res = {1'b1, 4'(c - 8'h30)};
                [8'h41:8'h46]: res = {1'b1, 4'(c - 8'h41 + 8'd10)};
                [8'h61:8'h66]: res = {1'b1, 4'(c - 8'h61 + 8'd10)};
                default:       res = 5'd0;
            endcase
            return res;
        end
    endfunction

    logic [4:0] hex;

    always_comb begin
        hex                   = hex_decode(i_in_data.character);
        o_cls.end_of_line     = i_in_data.end_of_line;
        o_cls.nibble          = hex[3:0];
        o_cls.legal           = hex[4] || (i_in_data.character == CHAR_NEWLINE)
                                || (i_in_data.character == CHAR_SPACE);
        o_cls.character       = i_in_data.character;
    end

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    property p_no_push_full;
        @(posedge i_clk) disable iff (!i_rst_n) i_q_status.full |-> !o_push;
    endproperty
    assert property (p_no_push_full) else $error("push while queue full");

    property p_legal_hex;
        @(posedge i_clk) disable iff (!i_rst_n) (o_cls.nibble != 4'd0) |-> o_cls.legal;
    endproperty
    assert property (p_legal_hex) else $error("nonzero nibble on illegal character");

    property p_status_sane;
        @(posedge i_clk) disable iff (!i_rst_n) !(i_q_status.full && i_q_status.empty);
    endproperty
    assert property (p_status_sane) else $error("queue both full and empty");

endmodule

// File: hdl/srec_queue.sv
// short fifo of classified characters between front and back
// depends on srec_pkg
module srec_queue
    import srec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls      i_push_data,
    input  logic      i_pop,
    output t_cls      o_pop_data,
    output t_q_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_cls             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data     = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CNT_FULL;
    endproperty
    assert property (p_count_bound) else $error("queue count overflow");

    property p_no_pop_empty;
        @(posedge i_clk) disable iff (!i_rst_n) (r_count == '0) |-> !i_pop;
    endproperty
    assert property (p_no_pop_empty) else $error("pop from empty queue");

    property p_ptr_track;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_count == '0) |-> (r_wr_ptr == r_rd_ptr);
    endproperty
    assert property (p_ptr_track) else $error("queue pointers out of step");

endmodule

// File: hdl/srec_back.sv
// back end: pairs nibbles into bytes, sums them and forms the line verdict
// depends on srec_pkg; drains srec_queue into a single output register
module srec_back
    import srec_pkg::*;
#(
    parameter int MAX_LINE_CHARS = MAX_LINE_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_status,
    input  t_cls      i_cls,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_result   o_out_data
);

    localparam int LEN_W = $clog2(MAX_LINE_CHARS + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE_CHARS);
    localparam logic [LEN_W-1:0] LEN_PAIR_START = LEN_W'(2);

    logic [LEN_W-1:0] r_line_length, n_line_length;
    logic [7:0]       r_char_position, n_char_position;
    logic [3:0]       r_high_nibble, n_high_nibble;
    logic [7:0]       r_pending_byte, n_pending_byte;
    logic             r_pending_valid, n_pending_valid;
    logic [7:0]       r_running_sum, n_running_sum;
    logic             r_bad_seen, n_bad_seen;
    logic [7:0]       r_first_bad_char, n_first_bad_char;
    logic [7:0]       r_first_bad_pos, n_first_bad_pos;
    logic             r_half_pair, n_half_pair;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic             out_free;
    logic [7:0]       computed;
    t_status          status;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = !i_q_status.empty && (!i_cls.end_of_line || out_free);
    assign computed = SUM_BASE - r_running_sum;

    always_comb begin
        if (r_bad_seen) begin
            status = STATUS_ILLEGAL;
        end else if (!r_pending_valid) begin
            status = STATUS_SHORT;
        end else if (r_half_pair) begin
            status = STATUS_ODD;
        end else if (r_pending_byte != computed) begin
            status = STATUS_MISMATCH;
        end else begin
            status = STATUS_OK;
        end
    end

    always_comb begin
        n_line_length    = r_line_length;
        n_char_position  = r_char_position;
        n_high_nibble    = r_high_nibble;
        n_pending_byte   = r_pending_byte;
        n_pending_valid  = r_pending_valid;
        n_running_sum    = r_running_sum;
        n_bad_seen       = r_bad_seen;
        n_first_bad_char = r_first_bad_char;
        n_first_bad_pos  = r_first_bad_pos;
        n_half_pair      = r_half_pair;
        n_out_valid      = r_out_valid && i_out_stall;
        n_out            = r_out;

        if (o_pop && i_cls.end_of_line) begin
            n_out_valid          = 1'b1;
            n_out.line_ok        = (status == STATUS_OK);
            n_out.status         = status;
            n_out.expected_sum   = r_pending_valid ? r_pending_byte : 8'd0;
            n_out.computed_sum   = computed;
            n_out.bad_character  = r_bad_seen ? r_first_bad_char : 8'd0;
            n_out.bad_position   = r_bad_seen ? r_first_bad_pos : 8'd0;
            n_line_length    = '0;
            n_char_position  = '0;
            n_high_nibble    = '0;
            n_pending_byte   = '0;
            n_pending_valid  = 1'b0;
            n_running_sum    = '0;
            n_bad_seen       = 1'b0;
            n_first_bad_char = '0;
            n_first_bad_pos  = '0;
            n_half_pair      = 1'b0;
        end else if (o_pop && (r_line_length < LEN_MAX)) begin
            // record type letter is never checked
            if ((r_char_position != 8'd0) && !r_bad_seen && !i_cls.legal) begin
                n_bad_seen       = 1'b1;
                n_first_bad_char = i_cls.character;
                n_first_bad_pos  = r_char_position;
            end
            if (r_line_length >= LEN_PAIR_START) begin
                if (!r_half_pair) begin
                    n_high_nibble = i_cls.nibble;
                    n_half_pair   = 1'b1;
                end else begin
                    if (r_pending_valid) begin
                        n_running_sum = r_running_sum + r_pending_byte;
                    end
                    n_pending_byte  = {r_high_nibble, i_cls.nibble};
                    n_pending_valid = 1'b1;
                    n_half_pair     = 1'b0;
                end
            end
            n_line_length = r_line_length + 1'b1;
            if (r_char_position != POS_MAX) begin
                n_char_position = r_char_position + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length    <= '0;
            r_char_position  <= '0;
            r_high_nibble    <= '0;
            r_pending_byte   <= '0;
            r_pending_valid  <= 1'b0;
            r_running_sum    <= '0;
            r_bad_seen       <= 1'b0;
            r_first_bad_char <= '0;
            r_first_bad_pos  <= '0;
            r_half_pair      <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_line_length    <= n_line_length;
            r_char_position  <= n_char_position;
            r_high_nibble    <= n_high_nibble;
            r_pending_byte   <= n_pending_byte;
            r_pending_valid  <= n_pending_valid;
            r_running_sum    <= n_running_sum;
            r_bad_seen       <= n_bad_seen;
            r_first_bad_char <= n_first_bad_char;
            r_first_bad_pos  <= n_first_bad_pos;
            r_half_pair      <= n_half_pair;
            r_out_valid      <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    property p_clear_after_eol;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_pop && i_cls.end_of_line) |=> (r_line_length == '0) && !r_bad_seen;
    endproperty
    assert property (p_clear_after_eol) else $error("line state not cleared");

    property p_ok_matches_status;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_out_valid |-> (r_out.line_ok == (r_out.status == STATUS_OK));
    endproperty
    assert property (p_ok_matches_status) else $error("line_ok disagrees with status");

    property p_bad_pos_status;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_out_valid |-> ((r_out.bad_position != 8'd0) ==
                             (r_out.status == STATUS_ILLEGAL));
    endproperty
    assert property (p_bad_pos_status) else $error("bad position without illegal status");

endmodule

// File: hdl/srec_line_checksum_checker.sv
// top level of the s-record line checksum checker
// depends on srec_pkg, srec_front, srec_queue and srec_back
//
// Takes one line character per cycle while o_in_stall is low and gives one
// verdict per line when an end-of-line transaction arrives; characters past
// MAX_LINE_CHARS are ignored and positions saturate at 255. Sustained rate is
// one transaction per clock while verdicts are taken: the front classifies
// each character on entry into a two-entry queue, and the back updates its
// 8-bit pair/sum registers once per popped entry. Verdicts are registered;
// the output register is reloaded in the cycle it is taken, and the back
// only holds on end-of-line while an untaken verdict is stalled.
module srec_line_checksum_checker
    import srec_pkg::*;
#(
    parameter int MAX_LINE_CHARS = MAX_LINE_CHARS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_result  o_out_data
);

    t_q_status q_status;
    t_cls      push_cls;
    t_cls      pop_cls;
    logic      push;
    logic      pop;

    srec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cls      (push_cls)
    );

    srec_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cls),
        .i_pop       (pop),
        .o_pop_data  (pop_cls),
        .o_status    (q_status)
    );

    srec_back #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_cls       (pop_cls),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: bench/tb_srec_line_checksum_checker.sv
// self-checking bench for srec_line_checksum_checker: directed lines, then random records
// depends on srec_pkg and the checker rtl; predicts each verdict or takes a directed one, and compares field by field
module tb_srec_line_checksum_checker
    import srec_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_CAP     = MAX_LINE_CHARS_DEF;
    localparam int RANDOM_ITEMS = 1750;
    localparam int PRINT_CAP    = 100;
    localparam t_result NO_WANT = '0;

    typedef struct packed {
        logic    typed;
        t_result want;
    } t_override;

    typedef struct {
        t_in_item item;
        bit       typed;
        t_result  want;
    } t_dir_row;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_in_item in_data = '0;
    logic     out_stall = 1'b0;
    logic     in_stall;
    logic     out_valid;
    t_result  out_data;

    srec_line_checksum_checker u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_srec_line_checksum_checker: errors");
        $finish;
    end

    // line state of the predictor
    int unsigned line_len = 0;
    logic [7:0]  pos_cnt = '0;
    logic [3:0]  hi_nib = '0;
    logic [7:0]  last_pair = '0;
    bit          pair_seen = 1'b0;
    logic [7:0]  sum_acc = '0;
    bit          illegal_seen = 1'b0;
    logic [7:0]  illegal_char = '0;
    logic [7:0]  illegal_pos = '0;
    bit          nib_pending = 1'b0;

    t_result    verdict_q[$];
    t_override  typed_q[$];
    t_dir_row   dir_rows[$];
    logic [7:0] line_buf[$];

    int err_count = 0;
    int verdict_count = 0;
    int status_seen[5] = '{default: 0};
    int longest_line = 0;
    int items_sent = 0;
    int burst_left = 0;

    function automatic bit is_hex_digit(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        return 4'h0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 10) return 8'("0" + v);
        return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP) $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    task automatic clear_line_state();
        line_len     = 0;
        pos_cnt      = '0;
        hi_nib       = '0;
        last_pair    = '0;
        pair_seen    = 1'b0;
        sum_acc      = '0;
        illegal_seen = 1'b0;
        illegal_char = '0;
        illegal_pos  = '0;
        nib_pending  = 1'b0;
    endtask

    // one accepted transaction into the predictor; a verdict is queued on end of line
    task automatic judge_item(input t_in_item it);
        t_result   r;
        t_override ov;
        logic [7:0] c;
        c = it.character;
        if (!it.end_of_line) begin
            if (line_len < LINE_CAP) begin
                if (pos_cnt >= 1 && !illegal_seen &&
                    !(is_hex_digit(c) || c == CHAR_NEWLINE || c == CHAR_SPACE)) begin
                    illegal_seen = 1'b1;
                    illegal_char = c;
                    illegal_pos  = pos_cnt;
                end
                if (line_len >= 2) begin
                    if (!nib_pending) begin
                        hi_nib      = hex_value(c);
                        nib_pending = 1'b1;
                    end else begin
                        if (pair_seen) sum_acc = sum_acc + last_pair;
                        last_pair   = {hi_nib, hex_value(c)};
                        pair_seen   = 1'b1;
                        nib_pending = 1'b0;
                    end
                end
                line_len++;
                if (pos_cnt != POS_MAX) pos_cnt++;
            end
        end else begin
            r.computed_sum = SUM_BASE - sum_acc;
            if (illegal_seen)                   r.status = STATUS_ILLEGAL;
            else if (!pair_seen)                r.status = STATUS_SHORT;
            else if (nib_pending)               r.status = STATUS_ODD;
            else if (last_pair != r.computed_sum) r.status = STATUS_MISMATCH;
            else                                r.status = STATUS_OK;
            r.line_ok       = (r.status == STATUS_OK);
            r.expected_sum  = pair_seen ? last_pair : 8'h00;
            r.bad_character = illegal_seen ? illegal_char : 8'h00;
            r.bad_position  = illegal_seen ? illegal_pos : 8'h00;
            ov = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
            verdict_q.push_back(ov.typed ? ov.want : r);
            clear_line_state();
        end
    endtask

    // checks leaving verdicts, then feeds accepted transactions to the predictor
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = out_data;
                verdict_count++;
                if (got.status < 5) status_seen[got.status]++;
                if (verdict_q.size() == 0) begin
                    flag_error($sformatf("verdict %0d arrived with none expected", verdict_count));
                end else begin
                    want = verdict_q.pop_front();
                    if (got.line_ok !== want.line_ok)
                        flag_error($sformatf("verdict %0d line_ok %b want %b",
                                             verdict_count, got.line_ok, want.line_ok));
                    if (got.status !== want.status)
                        flag_error($sformatf("verdict %0d status %0d want %0d",
                                             verdict_count, got.status, want.status));
                    if (got.expected_sum !== want.expected_sum)
                        flag_error($sformatf("verdict %0d expected_sum %h want %h",
                                             verdict_count, got.expected_sum, want.expected_sum));
                    if (got.computed_sum !== want.computed_sum)
                        flag_error($sformatf("verdict %0d computed_sum %h want %h",
                                             verdict_count, got.computed_sum, want.computed_sum));
                    if (got.bad_character !== want.bad_character)
                        flag_error($sformatf("verdict %0d bad_character %h want %h",
                                             verdict_count, got.bad_character,
                                             want.bad_character));
                    if (got.bad_position !== want.bad_position)
                        flag_error($sformatf("verdict %0d bad_position %0d want %0d",
                                             verdict_count, got.bad_position,
                                             want.bad_position));
                end
            end
            if (in_valid && !in_stall) judge_item(in_data);
        end
    end

    // receiver stall pattern: picks a random mode each time stall_cnt wraps
    logic [7:0] stall_cnt = '0;
    logic [1:0] stall_mode = '0;
    always @(posedge clk) begin
        stall_cnt <= stall_cnt + 1'b1;
        if (stall_cnt == 8'hFF) stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= ($urandom_range(0, 99) < 30);
            2'd2: out_stall <= stall_cnt[2];
            default: out_stall <= ($urandom_range(0, 99) < 85);
        endcase
    end

    task automatic send_item(input logic [7:0] c, input logic eol);
        in_valid <= 1'b1;
        in_data  <= '{character: c, end_of_line: eol};
        do @(posedge clk); while (in_stall);
    endtask

    // bursts of random length, random gaps between them
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end else begin
            burst_left--;
        end
    endtask

    // hold off the sender until every queued verdict has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic add_row(input logic [7:0] c, input logic eol, input bit typed,
                           input t_result want);
        t_dir_row row;
        row.item  = '{character: c, end_of_line: eol};
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic push_byte(input logic [7:0] b);
        line_buf.push_back(hex_char(b[7:4], $urandom_range(0, 1)));
        line_buf.push_back(hex_char(b[3:0], $urandom_range(0, 1)));
    endtask

    // one random line: well-formed records, damaged records and some plain noise
    task automatic build_line(input bit long_line);
        int n;
        int kind;
        int idx;
        int keep;
        logic [7:0] b;
        logic [7:0] sum;
        line_buf.delete();
        if (!long_line && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n = long_line ? $urandom_range(125, 140) : $urandom_range(0, 18);
        line_buf.push_back("S");
        line_buf.push_back(8'("0" + $urandom_range(0, 9)));
        b   = 8'(n + 1);
        sum = b;
        push_byte(b);
        repeat (n) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum + b;
            push_byte(b);
        end
        push_byte(SUM_BASE - sum);
        kind = long_line ? 0 : $urandom_range(0, 9);
        idx  = $urandom_range(1, line_buf.size() - 1);
        case (kind)
            5: line_buf[idx] = 8'($urandom_range(0, 255));
            6: line_buf.delete((idx < 2) ? 2 : idx);
            7: line_buf.insert(idx, $urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE);
            8: begin
                keep = $urandom_range(0, 3);
                while (line_buf.size() > keep) void'(line_buf.pop_back());
            end
            9: line_buf[line_buf.size() - 1] = hex_char(4'($urandom_range(0, 15)), 1'b0);
            default: ;
        endcase
        // an illegal character on the last counted position exercises position saturation
        if (long_line && line_buf.size() >= LINE_CAP && $urandom_range(0, 2) != 0) begin
            do b = 8'($urandom_range(0, 255));
            while (is_hex_digit(b) || b == CHAR_NEWLINE || b == CHAR_SPACE);
            line_buf[LINE_CAP - 1] = b;
        end
    endtask

    initial begin
        int line_no;
        int wait_cnt;
        t_override ov;

        // end of line straight after reset, its character ignored
        add_row(8'hFF, 1'b1, 1'b1,
                t_result'{1'b0, STATUS_SHORT, 8'h00, SUM_BASE, 8'h00, 8'h00});
        // smallest good record: pairs 00 then checksum FF
        add_row("S", 1'b0, 1'b0, NO_WANT);
        add_row("1", 1'b0, 1'b0, NO_WANT);
        add_row("0", 1'b0, 1'b0, NO_WANT);
        add_row("0", 1'b0, 1'b0, NO_WANT);
        add_row("F", 1'b0, 1'b0, NO_WANT);
        add_row("F", 1'b0, 1'b0, NO_WANT);
        add_row(8'h00, 1'b1, 1'b1,
                t_result'{1'b1, STATUS_OK, 8'hFF, SUM_BASE, 8'h00, 8'h00});
        // nul right after the type letter, then an all-ones byte
        add_row("S", 1'b0, 1'b0, NO_WANT);
        add_row(8'h00, 1'b0, 1'b0, NO_WANT);
        add_row(8'hFF, 1'b0, 1'b0, NO_WANT);
        add_row(8'h00, 1'b1, 1'b1,
                t_result'{1'b0, STATUS_ILLEGAL, 8'h00, SUM_BASE, 8'h00, 8'h01});
        // lowercase digit and newline inside a pair, odd leftover
        add_row("S", 1'b0, 1'b0, NO_WANT);
        add_row("9", 1'b0, 1'b0, NO_WANT);
        add_row("a", 1'b0, 1'b0, NO_WANT);
        add_row(CHAR_NEWLINE, 1'b0, 1'b0, NO_WANT);
        add_row("C", 1'b0, 1'b0, NO_WANT);
        add_row(8'h7F, 1'b1, 1'b0, NO_WANT);
        // checksum mismatch with a space as a nibble
        add_row("S", 1'b0, 1'b0, NO_WANT);
        add_row("1", 1'b0, 1'b0, NO_WANT);
        add_row("1", 1'b0, 1'b0, NO_WANT);
        add_row("2", 1'b0, 1'b0, NO_WANT);
        add_row(CHAR_SPACE, 1'b0, 1'b0, NO_WANT);
        add_row("4", 1'b0, 1'b0, NO_WANT);
        add_row(8'h80, 1'b1, 1'b0, NO_WANT);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].item.end_of_line) begin
                ov.typed = dir_rows[i].typed;
                ov.want  = dir_rows[i].want;
                typed_q.push_back(ov);
            end
            send_item(dir_rows[i].item.character, dir_rows[i].item.end_of_line);
            pace();
        end
        drain();

        line_no = 0;
        while (items_sent < RANDOM_ITEMS) begin
            build_line(line_no == 4 || $urandom_range(0, 39) == 0);
            if (line_buf.size() > longest_line) longest_line = line_buf.size();
            foreach (line_buf[i]) begin
                send_item(line_buf[i], 1'b0);
                pace();
            end
            typed_q.push_back('0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
            pace();
            items_sent += line_buf.size() + 1;
            if (line_no % 20 == 19) drain();
            line_no++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait_cnt = 0;
        while (verdict_q.size() != 0 && wait_cnt < 5000) begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (8) @(posedge clk);
        if (verdict_q.size() != 0)
            flag_error($sformatf("%0d verdicts never arrived", verdict_q.size()));

        $display("judged %0d lines (%0d random, longest %0d chars): ok %0d, illegal %0d,",
                 verdict_count, line_no, longest_line, status_seen[STATUS_OK],
                 status_seen[STATUS_ILLEGAL]);
        $display("  too short %0d, mismatch %0d, odd length %0d; %0d mismatches",
                 status_seen[STATUS_SHORT], status_seen[STATUS_MISMATCH],
                 status_seen[STATUS_ODD], err_count);
        if (err_count == 0) begin
            $display("tb_srec_line_checksum_checker: clean");
        end else begin
            $display("tb_srec_line_checksum_checker: errors");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/srec_pkg.sv
hdl/srec_front.sv
hdl/srec_queue.sv
hdl/srec_back.sv
hdl/srec_line_checksum_checker.sv
bench/tb_srec_line_checksum_checker.sv
